// ----- hw/rtl/vbfq_pkg.sv -----
// vbfq_pkg: types and constants shared by the voxel box fill and query block
// payload structs for both channels, register indexes, controller/datapath structs
// no dependencies
package vbfq_pkg;

  localparam int SIZE_W     = 6;
  localparam int COORD_W    = 8;
  localparam int VALUE_W    = 8;
  localparam int CFG_IDX_W  = 2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 2'd2;

  // item functions
  localparam logic FUNC_FILL  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic                      func;
    logic signed [COORD_W-1:0] min_x;
    logic signed [COORD_W-1:0] min_y;
    logic signed [COORD_W-1:0] min_z;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] max_y;
    logic signed [COORD_W-1:0] max_z;
    logic [VALUE_W-1:0]        value;
    logic                      invert_match;
  } vbfq_in_t;

  typedef struct packed {
    logic found;
    logic outside;
  } vbfq_out_t;

  // controller to datapath
  typedef struct packed {
    logic clear;        // write one zero entry of the clearing sweep
    logic capture;      // take the input item
    logic clip;         // clip the box and work out the plane area
    logic base;         // partial products of the start address
    logic start;        // load walk counters and addresses
    logic step;         // visit one voxel
    logic load_result;  // move the outcome into the output register
  } vbfq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic outside;
    logic empty;
    logic last;
  } vbfq_status_t;

endpackage

// ----- hw/rtl/vbfq_ctrl.sv -----
// vbfq_ctrl: sequencing state machine of the voxel box fill and query block
// drives datapath commands, input ready and output valid
// depends on vbfq_pkg
module vbfq_ctrl import vbfq_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  output vbfq_cmd_t    cmd,
  input  vbfq_status_t status
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CLIP,
    ST_BASE,
    ST_START,
    ST_WALK,
    ST_DRAIN,
    ST_DONE
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd             = '0;
    cmd.clear       = (state == ST_CLEAR);
    cmd.capture     = (state == ST_IDLE) && in_valid;
    cmd.clip        = (state == ST_CLIP);
    cmd.base        = (state == ST_BASE);
    cmd.start       = (state == ST_START);
    cmd.step        = (state == ST_WALK);
    cmd.load_result = (state == ST_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_result) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          if (status.clear_last) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_CLIP;
          end
        end
        ST_CLIP: begin
          state <= ST_BASE;
        end
        ST_BASE: begin
          // nothing to visit when outside or clipped to nothing
          if (status.outside || status.empty) begin
            state <= ST_DONE;
          end else begin
            state <= ST_START;
          end
        end
        ST_START: begin
          state <= ST_WALK;
        end
        ST_WALK: begin
          if (status.last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          // last read compares in this cycle
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_result |-> (!out_valid || out_ready))
    else $error("result loaded over a pending one");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item taken while one is in work");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DONE))
    else $error("result shown without finishing an item");

endmodule

// ----- hw/rtl/vbfq_datapath.sv -----
// vbfq_datapath: size registers, box clipping, voxel walk and the voxel store
// carries out the commands of vbfq_ctrl and holds the result register
// depends on vbfq_pkg
module vbfq_datapath import vbfq_pkg::*; #(
  parameter int MAX_DIM    = 32,
  parameter int VALUE_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data,
  input  vbfq_in_t             in_data,
  output vbfq_out_t            out_data,
  input  vbfq_cmd_t            cmd,
  output vbfq_status_t         status
);

  localparam int DEPTH = MAX_DIM * MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_DIM);

  logic [SIZE_W-1:0] size_reg [3];
  logic [SIZE_W-1:0] n [3];

  // captured item
  logic                      func;
  logic signed [COORD_W-1:0] raw_lo [3];
  logic signed [COORD_W-1:0] raw_hi [3];
  logic [VALUE_BITS-1:0]     val;
  logic                      inv;

  // clipped box
  logic [CW-1:0] box_lo [3];
  logic [CW-1:0] box_hi [3];
  logic          outside;
  logic          empty;
  logic [AW-1:0] area;
  logic [AW-1:0] prod_y;
  logic [AW-1:0] prod_z;

  // walk
  logic [CW-1:0] pos [3];
  logic [AW-1:0] addr;
  logic [AW-1:0] row_addr;
  logic [AW-1:0] plane_addr;
  logic [AW-1:0] clr_cnt;

  logic [VALUE_BITS-1:0] store [DEPTH];
  logic [VALUE_BITS-1:0] rd_data;
  logic                  rd_pend;
  logic                  found;
  vbfq_out_t             res;

  // combinational clip terms
  logic                   c_out [3];
  logic [CW-1:0]          c_lo [3];
  logic [CW-1:0]          c_hi [3];
  logic                   c_empty [3];
  logic [2*SIZE_W-1:0]    area_full;
  logic [CW+SIZE_W-1:0]   prod_y_full;
  logic [CW+AW-1:0]       prod_z_full;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      size_reg[0] <= SIZE_RESET;
      size_reg[1] <= SIZE_RESET;
      size_reg[2] <= SIZE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SIZE_X: size_reg[0] <= cfg_data;
        CFG_SIZE_Y: size_reg[1] <= cfg_data;
        CFG_SIZE_Z: size_reg[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // sizes above the store dimension are used as the store dimension
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      n[a] = (int'(size_reg[a]) > MAX_DIM) ? SIZE_W'(MAX_DIM) : size_reg[a];
    end
  end

  always_comb begin
    logic signed [COORD_W:0] lo_s;
    logic signed [COORD_W:0] hi_s;
    logic signed [COORD_W:0] n_s;
    logic signed [COORD_W:0] lo_c;
    logic signed [COORD_W:0] hi_c;
    for (int a = 0; a < 3; a++) begin
      lo_s = {raw_lo[a][COORD_W-1], raw_lo[a]};
      hi_s = {raw_hi[a][COORD_W-1], raw_hi[a]};
      n_s  = $signed({{(COORD_W+1-SIZE_W){1'b0}}, n[a]});
      c_out[a]   = (hi_s < 0) || (lo_s >= n_s);
      lo_c       = (lo_s < 0) ? '0 : lo_s;
      hi_c       = (hi_s > n_s - 1) ? n_s - 1 : hi_s;
      c_empty[a] = (lo_c > hi_c);
      c_lo[a]    = CW'($unsigned(lo_c));
      c_hi[a]    = CW'($unsigned(hi_c));
    end
  end

  assign area_full   = n[0] * n[1];
  assign prod_y_full = box_lo[1] * n[0];
  assign prod_z_full = box_lo[2] * area;

  // item capture, clip and start address
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func      <= in_data.func;
      raw_lo[0] <= in_data.min_x;
      raw_lo[1] <= in_data.min_y;
      raw_lo[2] <= in_data.min_z;
      raw_hi[0] <= in_data.max_x;
      raw_hi[1] <= in_data.max_y;
      raw_hi[2] <= in_data.max_z;
      val       <= VALUE_BITS'(in_data.value);
      inv       <= in_data.invert_match;
    end
    if (cmd.clip) begin
      for (int a = 0; a < 3; a++) begin
        box_lo[a] <= c_lo[a];
        box_hi[a] <= c_hi[a];
      end
      area <= AW'(area_full);
    end
    if (cmd.base) begin
      prod_y <= AW'(prod_y_full);
      prod_z <= AW'(prod_z_full);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      outside <= 1'b0;
      empty   <= 1'b0;
    end else if (cmd.clip) begin
      outside <= c_out[0] || c_out[1] || c_out[2];
      empty   <= c_empty[0] || c_empty[1] || c_empty[2];
    end
  end

  // x fastest, then y, then z
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      pos[0]     <= box_lo[0];
      pos[1]     <= box_lo[1];
      pos[2]     <= box_lo[2];
      addr       <= AW'(box_lo[0]) + prod_y + prod_z;
      row_addr   <= AW'(box_lo[0]) + prod_y + prod_z;
      plane_addr <= AW'(box_lo[0]) + prod_y + prod_z;
    end else if (cmd.step) begin
      if (pos[0] != box_hi[0]) begin
        pos[0] <= pos[0] + CW'(1);
        addr   <= addr + AW'(1);
      end else if (pos[1] != box_hi[1]) begin
        pos[0]   <= box_lo[0];
        pos[1]   <= pos[1] + CW'(1);
        row_addr <= row_addr + AW'(n[0]);
        addr     <= row_addr + AW'(n[0]);
      end else begin
        pos[0]     <= box_lo[0];
        pos[1]     <= box_lo[1];
        pos[2]     <= pos[2] + CW'(1);
        plane_addr <= plane_addr + area;
        row_addr   <= plane_addr + area;
        addr       <= plane_addr + area;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  // voxel store: one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      store[clr_cnt] <= '0;
    end else if (cmd.step && (func == FUNC_FILL)) begin
      store[addr] <= val;
    end
    if (cmd.step) begin
      rd_data <= store[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
      found   <= 1'b0;
    end else begin
      rd_pend <= cmd.step && (func == FUNC_QUERY);
      if (cmd.capture) begin
        found <= 1'b0;
      end else if (rd_pend && ((rd_data == val) != inv)) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      res.found   <= found && !outside;
      res.outside <= outside;
    end
  end

  assign out_data = res;

  assign status.clear_last = (clr_cnt == AW'(DEPTH - 1));
  assign status.outside    = outside;
  assign status.empty      = empty;
  assign status.last       = (pos[0] == box_hi[0]) && (pos[1] == box_hi[1])
                             && (pos[2] == box_hi[2]);

  a_step_in_box: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (!outside && !empty))
    else $error("voxel visited for a box with nothing to visit");

  a_addr_range: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (int'(addr) < DEPTH))
    else $error("walk address beyond the store");

  a_found_query: assert property (@(posedge clk) disable iff (rst)
    found |-> (func == FUNC_QUERY))
    else $error("match flagged on a fill");

endmodule

// ----- hw/rtl/voxel_box_fill_and_query_top.sv -----
// voxel_box_fill_and_query_top: voxel store with box fill and box overlap query
// joins the controller vbfq_ctrl and the datapath vbfq_datapath
// depends on vbfq_pkg
//
// Input channel in_valid/in_ready/in_data carries one box item: a fill writes value
// into every voxel of the clipped box, a query reports whether any voxel of it
// equals value (or differs, with invert_match). Output channel out_valid/out_ready/
// out_data carries one result per item: found and outside.
// Sizes per axis are written through cfg_we/cfg_index/cfg_data while the block is idle;
// the user is bound to that, as the block itself does not enforce it. After reset
// the store is swept to zero, one entry a cycle, all MAX_DIM**3 entries
// (32768 at the default); in_ready stays low until the sweep ends.
// An item is worked on alone. The walk visits one voxel a cycle through the single
// store port. An item is captured, clipped, given its start address, walked and
// drained before its result is loaded; a box outside the grid, or clipped to
// nothing, skips the walk and drain. The result sits in an output register, so the
// next item is taken while it waits; a finished item whose result cannot yet be
// loaded holds the block until the receiver takes the pending one.
module voxel_box_fill_and_query_top import vbfq_pkg::*; #(
  parameter int MAX_DIM    = 32,
  parameter int VALUE_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  vbfq_in_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output vbfq_out_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data
);

  vbfq_cmd_t    cmd;
  vbfq_status_t status;

  vbfq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  vbfq_datapath #(
    .MAX_DIM    (MAX_DIM),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

// ----- test/voxel_box_checker.sv -----
// voxel_box_checker: watches the box and result transfers, keeps its own voxel grid,
// predicts found/outside for every accepted box and compares in order
// depends on vbfq_pkg
module voxel_box_checker import vbfq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  vbfq_in_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  vbfq_out_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data,
  output int                   n_waiting,
  output int                   mismatches,
  output int                   checked,
  output int                   hits
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIM = 32;

  logic [VALUE_W-1:0] grid [DIM*DIM*DIM];
  logic [SIZE_W-1:0]  len_x, len_y, len_z;
  vbfq_out_t          result_q [$];

  // clips the box, then fills it or scans it exactly as the block walks it
  function automatic vbfq_out_t visit_box(input vbfq_in_t b);
    int lo [3];
    int hi [3];
    int n [3];
    int a, x, y, z, idx;
    vbfq_out_t r;
    r = '0;
    lo[0] = int'(b.min_x);
    lo[1] = int'(b.min_y);
    lo[2] = int'(b.min_z);
    hi[0] = int'(b.max_x);
    hi[1] = int'(b.max_y);
    hi[2] = int'(b.max_z);
    n[0] = (len_x > DIM) ? DIM : int'(len_x);
    n[1] = (len_y > DIM) ? DIM : int'(len_y);
    n[2] = (len_z > DIM) ? DIM : int'(len_z);
    for (a = 0; a < 3; a++) begin
      if (hi[a] < 0 || lo[a] >= n[a]) begin
        r.outside = 1'b1;
        return r;
      end
      if (hi[a] > n[a] - 1) hi[a] = n[a] - 1;
      if (lo[a] < 0) lo[a] = 0;
    end
    for (z = lo[2]; z <= hi[2]; z++) begin
      for (y = lo[1]; y <= hi[1]; y++) begin
        for (x = lo[0]; x <= hi[0]; x++) begin
          idx = x + y * n[0] + z * n[0] * n[1];
          if (b.func == FUNC_FILL) begin
            grid[idx] = b.value;
          end else if (b.invert_match != (grid[idx] == b.value)) begin
            r.found = 1'b1;
          end
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    vbfq_out_t want;
    int bad;
    int i;
    bad = 0;
    if (rst) begin
      for (i = 0; i < DIM*DIM*DIM; i++) grid[i] = '0;
      len_x = SIZE_RESET;
      len_y = SIZE_RESET;
      len_z = SIZE_RESET;
      result_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SIZE_X: len_x = cfg_data;
          CFG_SIZE_Y: len_y = cfg_data;
          CFG_SIZE_Z: len_z = cfg_data;
          default: ;
        endcase
      end
      // results first, so a box taken at this edge cannot pair with an older result
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          bad++;
          $display("%0t: result expected none, got found=%b outside=%b",
                   $time, out_data.found, out_data.outside);
        end else begin
          want = result_q.pop_front();
          if (out_data.found !== want.found) begin
            bad++;
            $display("%0t: found expected %b, got %b", $time, want.found, out_data.found);
          end
          if (out_data.outside !== want.outside) begin
            bad++;
            $display("%0t: outside expected %b, got %b",
                     $time, want.outside, out_data.outside);
          end
          checked <= checked + 1;
          if (out_data.found === 1'b1) hits <= hits + 1;
        end
      end
      if (in_valid && in_ready) result_q.push_back(visit_box(in_data));
    end
    n_waiting <= result_q.size();
    mismatches <= mismatches + bad;
  end

endmodule

// ----- test/tb.sv -----
// tb: drives boxes and grid sizes into voxel_box_fill_and_query_top and gives the verdict
// prediction and comparison sit in voxel_box_checker; depends on vbfq_pkg
module tb import vbfq_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int ITEMS = 1700;
  localparam int LONG_GAP = 60;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  vbfq_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  vbfq_out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SIZE_W-1:0] cfg_data = '0;

  int n_waiting, mismatches, checked, hits;
  int sent, fills, queries, settings;
  int gap_pct, stall_pct, stall_left;
  longint budget, cycles;
  logic [SIZE_W-1:0] sz_x, sz_y, sz_z;

  voxel_box_fill_and_query_top uut (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_we, .cfg_index, .cfg_data
  );

  voxel_box_checker score (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_we, .cfg_index, .cfg_data, .n_waiting, .mismatches, .checked, .hits
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver back-pressure: mostly short stalls, now and then a long one
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_pct != 0 && $urandom_range(99, 0) < stall_pct) begin
      out_ready <= 1'b0;
      stall_left <= ($urandom_range(9, 0) == 0) ? $urandom_range(LONG_GAP, 20)
                                                : $urandom_range(2, 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // cycle budget grows with the work handed to the block
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > budget) begin
      $display("timed out after %0d cycles", cycles);
      $display("[voxel_box_fill_and_query_top] ERROR");
      $finish;
    end
  end

  function automatic longint span(input logic signed [COORD_W-1:0] lo, hi);
    int d;
    d = int'(hi) - int'(lo) + 1;
    if (d < 0) d = 0;
    if (d > 32) d = 32;
    return d;
  endfunction

  function automatic int usable(input logic [SIZE_W-1:0] n);
    if (n == 0) return 1;
    return (n > 32) ? 32 : int'(n);
  endfunction

  function automatic vbfq_in_t box(input logic f, input int x0, y0, z0, x1, y1, z1,
                                   input int v, input logic inv);
    vbfq_in_t b;
    b.func = f;
    b.min_x = x0[COORD_W-1:0];
    b.min_y = y0[COORD_W-1:0];
    b.min_z = z0[COORD_W-1:0];
    b.max_x = x1[COORD_W-1:0];
    b.max_y = y1[COORD_W-1:0];
    b.max_z = z1[COORD_W-1:0];
    b.value = v[VALUE_W-1:0];
    b.invert_match = inv;
    return b;
  endfunction

  // mostly small in-grid boxes, some medium, a few whole-grid ones and raw noise
  function automatic vbfq_in_t make_box();
    int lo [3];
    int hi [3];
    int s [3];
    int roll, a, reach;
    s[0] = usable(sz_x);
    s[1] = usable(sz_y);
    s[2] = usable(sz_z);
    roll = $urandom_range(99, 0);
    reach = (roll < 72) ? 3 : 10;
    for (a = 0; a < 3; a++) begin
      if (roll >= 99) begin
        lo[a] = 0 - int'($urandom_range(40, 0));
        hi[a] = s[a] - 1 + int'($urandom_range(40, 0));
      end else if (roll >= 92) begin
        lo[a] = int'($urandom_range(255, 0)) - 128;
        hi[a] = int'($urandom_range(255, 0)) - 128;
      end else begin
        lo[a] = int'($urandom_range(s[a] - 1, 0));
        if ($urandom_range(7, 0) == 0) lo[a] = lo[a] - int'($urandom_range(3, 0));
        hi[a] = lo[a] + int'($urandom_range(reach, 0));
        if ($urandom_range(29, 0) == 0) hi[a] = lo[a] - 1;
      end
    end
    return box(($urandom_range(99, 0) < 45) ? FUNC_FILL : FUNC_QUERY,
               lo[0], lo[1], lo[2], hi[0], hi[1], hi[2],
               ($urandom_range(9, 0) < 7) ? $urandom_range(3, 0) : $urandom_range(255, 0),
               1'($urandom_range(1, 0)));
  endfunction

  task automatic send_box(input vbfq_in_t b);
    int gap;
    budget += 4 * (span(b.min_x, b.max_x) * span(b.min_y, b.max_y) * span(b.min_z, b.max_z)
                   + 8 + 2 * LONG_GAP);
    gap = 0;
    if (gap_pct != 0 && $urandom_range(99, 0) < gap_pct)
      gap = ($urandom_range(9, 0) == 0) ? $urandom_range(LONG_GAP, 20) : $urandom_range(3, 1);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    if (b.func == FUNC_FILL) fills++;
    else queries++;
  endtask

  // lets every outstanding result through, then a short settling pause
  task automatic drain();
    budget += 200;
    in_valid <= 1'b0;
    @(posedge clk);
    while (n_waiting != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_grid(input logic [SIZE_W-1:0] sx, sy, sz);
    sz_x = sx;
    sz_y = sy;
    sz_z = sz;
    settings++;
    cfg_we <= 1'b1;
    cfg_index <= CFG_SIZE_X;
    cfg_data <= sx;
    @(posedge clk);
    cfg_index <= CFG_SIZE_Y;
    cfg_data <= sy;
    @(posedge clk);
    cfg_index <= CFG_SIZE_Z;
    cfg_data <= sz;
    @(posedge clk);
    // spare index must leave the sizes alone
    cfg_index <= CFG_SPARE;
    cfg_data <= SIZE_W'($urandom_range(63, 0));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    int roll;
    roll = $urandom_range(19, 0);
    if (roll == 0) return '0;
    if (roll == 1) return SIZE_W'($urandom_range(63, 33));
    if (roll == 2) return SIZE_W'(32);
    return SIZE_W'($urandom_range(16, 1));
  endfunction

  initial begin : stimulus
    int phase, mode, n;
    budget = 4 * (32768 + 1000);
    sz_x = SIZE_RESET;
    sz_y = SIZE_RESET;
    sz_z = SIZE_RESET;
    gap_pct = 20;
    stall_pct = 20;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // fresh store, whole-grid fill, clipping at both ends, empty and outside boxes
    send_box(box(FUNC_QUERY, 0, 0, 0, 31, 31, 31, 0, 1'b0));
    send_box(box(FUNC_QUERY, -128, -128, -128, 127, 127, 127, 0, 1'b1));
    send_box(box(FUNC_FILL, -128, -128, -128, 127, 127, 127, 255, 1'b1));
    send_box(box(FUNC_QUERY, 31, 31, 31, 31, 31, 31, 255, 1'b0));
    send_box(box(FUNC_FILL, 0, 0, 0, 2, 1, 0, 8'h5a, 1'b0));
    send_box(box(FUNC_QUERY, 2, 1, 0, 5, 5, 5, 8'h5a, 1'b0));
    send_box(box(FUNC_QUERY, 0, 0, 0, 2, 1, 0, 8'h5a, 1'b1));
    send_box(box(FUNC_QUERY, 0, 0, 0, 3, 1, 0, 8'h5a, 1'b1));
    send_box(box(FUNC_QUERY, -5, 0, 0, -1, 4, 4, 0, 1'b0));
    send_box(box(FUNC_FILL, 0, 32, 0, 3, 40, 3, 7, 1'b0));
    send_box(box(FUNC_QUERY, 0, 0, 127, 0, 0, 127, 255, 1'b0));
    send_box(box(FUNC_FILL, -128, -128, -128, -128, -128, -128, 1, 1'b0));
    send_box(box(FUNC_QUERY, 32, 0, 0, 127, 31, 31, 255, 1'b1));
    send_box(box(FUNC_QUERY, 0, 5, 0, 3, 3, 3, 255, 1'b1));
    send_box(box(FUNC_FILL, 4, 0, 0, 3, 31, 31, 9, 1'b0));
    send_box(box(FUNC_QUERY, 3, 0, 0, 4, 0, 0, 9, 1'b0));
    send_box(box(FUNC_QUERY, -128, -1, -3, 0, 0, 0, 8'h5a, 1'b0));
    send_box(box(FUNC_FILL, 30, 30, 30, 127, 127, 127, 8'h80, 1'b0));
    send_box(box(FUNC_QUERY, 31, 31, 31, 31, 31, 31, 8'h80, 1'b0));
    send_box(box(FUNC_QUERY, 29, 29, 29, 30, 30, 30, 8'h80, 1'b1));

    // extreme sizes first, then random ones; the store is never cleared in between
    phase = 0;
    while (sent < ITEMS) begin
      drain();
      case (phase)
        0: set_grid(1, 1, 1);
        1: set_grid(0, 7, 7);
        2: set_grid(63, 2, 5);
        3: set_grid(32, 32, 1);
        4: set_grid(5, 0, 63);
        default: set_grid(pick_size(), pick_size(), pick_size());
      endcase
      mode = $urandom_range(3, 0);
      gap_pct = (mode == 0) ? 0 : (mode == 1) ? 15 : (mode == 2) ? 40 : 10;
      stall_pct = (mode == 0) ? 0 : (mode == 1) ? 15 : (mode == 2) ? 10 : 50;
      n = $urandom_range(120, 40);
      repeat (n) send_box(make_box());
      phase++;
    end
    drain();

    $display("%0d boxes sent (%0d fills, %0d queries) across %0d grid size settings",
             sent, fills, queries, settings);
    $display("%0d results checked, %0d with found set, %0d mismatches",
             checked, hits, mismatches);
    if (mismatches == 0) begin
      $display("[voxel_box_fill_and_query_top] OK");
    end else begin
      $display("[voxel_box_fill_and_query_top] ERROR");
    end
    $finish;
  end

endmodule
